// ----- rtl/ignition_rpm_advance_calc_core_assert.svh -----
// assertion macros for the ignition calculator
`ifndef IGNITION_RPM_ADVANCE_CALC_CORE_ASSERT_SVH
`define IGNITION_RPM_ADVANCE_CALC_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define IRA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define IRA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/irac_pkg.sv -----
// ---------------------------------------------------------------------------
// irac_pkg
// shared types and constants of the ignition rpm and advance calculator
// ---------------------------------------------------------------------------
package irac_pkg;
    localparam int unsigned PerW    = 24;
    localparam int unsigned FacW    = 27;
    localparam int unsigned OffW    = 8;
    localparam int unsigned AngNumW = 32;   // 180 * crank fits in 32 bits
    localparam int unsigned QW      = 32;   // quotient bits produced by cells
    localparam int unsigned NumCell = QW;
    localparam int unsigned RemW    = PerW + 1;

    localparam logic [FacW-1:0] RpmFactorRst = 27'd27656192;
    localparam logic [PerW-1:0] MinPeriodRst = 24'd2766;
    localparam logic [OffW-1:0] NotchOffRst  = 8'd28;

    localparam logic [1:0] RegRpmFactor = 2'd0;
    localparam logic [1:0] RegMinPeriod = 2'd1;
    localparam logic [1:0] RegNotchOff  = 2'd2;

    // per-item side info carried with the division
    typedef struct packed {
        logic            over;
        logic            valid;
        logic [OffW-1:0] off;
    } t_side;

    // one divider lane state handed from cell to cell
    typedef struct packed {
        logic [QW-1:0]   num;   // remaining numerator bits, shifted left
        logic [RemW-1:0] rem;
        logic [QW-1:0]   quo;
        logic [PerW-1:0] den;
    } t_lane;

    typedef struct packed {
        logic  vld;
        t_side side;
        t_lane rpm;
        t_lane ang;
    } t_cellbus;
endpackage

// ----- rtl/irac_cell.sv -----
// ---------------------------------------------------------------------------
// irac_cell
// one restoring-division step for both the rpm and the angle quotient
// ---------------------------------------------------------------------------
module irac_cell
    import irac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cellbus i_bus,
    output t_cellbus o_bus
);
    t_cellbus n_bus;
    t_cellbus r_bus;

    function automatic t_lane step(input t_lane l);
        t_lane      o;
        logic [RemW:0] tr;
        o  = l;
        tr = {l.rem, l.num[QW-1]};
        o.num = {l.num[QW-2:0], 1'b0};
        if (tr >= {2'b00, l.den}) begin
            tr = tr - {2'b00, l.den};
            o.quo = {l.quo[QW-2:0], 1'b1};
        end else begin
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        o.rem = tr[RemW-1:0];
        return o;
    endfunction

    always_comb begin
        n_bus     = i_bus;
        n_bus.rpm = step(i_bus.rpm);
        n_bus.ang = step(i_bus.ang);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else begin
            r_bus.vld <= i_bus.vld;
        end
        r_bus.side <= n_bus.side;
        r_bus.rpm  <= n_bus.rpm;
        r_bus.ang  <= n_bus.ang;
    end

    assign o_bus = r_bus;
endmodule

// ----- rtl/irac_digits.sv -----
// ---------------------------------------------------------------------------
// irac_digits
// saturates and clamps the quotients and splits them into decimal digits
// ---------------------------------------------------------------------------
module irac_digits
    import irac_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  t_side         i_side,
    input  logic [QW-1:0] i_rpm_q,
    input  logic [QW-1:0] i_ang_q,
    output logic          o_vld,
    output logic [3:0]    o_rpm_d [4],
    output logic          o_over,
    output logic [3:0]    o_adv_d [3],
    output logic          o_adv_valid,
    output logic          o_clamped
);
    logic [13:0] n_rpm, r_rpm;
    logic [9:0]  n_adv, r_adv;
    logic        n_over, n_clamp, r_over, r_clamp, r_avld, r_vld1, r_vld2;
    logic [QW-1:0] adiff;

    always_comb begin
        n_over  = i_side.over;
        n_rpm   = 14'd9999;
        if (!i_side.over) begin
            if (i_rpm_q > 32'd9999) n_over = 1'b1;
            else n_rpm = i_rpm_q[13:0];
        end
        adiff   = i_ang_q - {{(QW-OffW){1'b0}}, i_side.off};
        n_adv   = 10'd0;
        n_clamp = 1'b0;
        if (i_side.valid) begin
            if (i_ang_q < {{(QW-OffW){1'b0}}, i_side.off}) begin
                n_clamp = 1'b1;
            end else if (adiff > 32'd999) begin
                n_adv   = 10'd999;
                n_clamp = 1'b1;
            end else begin
                n_adv = adiff[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        r_rpm   <= n_rpm;
        r_adv   <= n_adv;
        r_over  <= n_over;
        r_clamp <= n_clamp;
        r_avld  <= i_side.valid;
    end

    // second stage: decimal split by reciprocal multiplies, exact up to 9999
    logic [3:0] n_rd [4];
    logic [3:0] n_ad [3];
    logic [3:0] r_rd [4];
    logic [3:0] r_ad [3];
    logic r_over2, r_clamp2, r_avld2;
    logic [3:0] rq1000;
    logic [6:0] rq100;
    logic [9:0] rq10;
    logic [3:0] aq100;
    logic [6:0] aq10;

    always_comb begin
        rq1000  = 4'((32'(r_rpm) * 32'd16778) >> 24);
        rq100   = 7'((32'(r_rpm) * 32'd5243) >> 19);
        rq10    = 10'((32'(r_rpm) * 32'd52429) >> 19);
        n_rd[0] = rq1000;
        n_rd[1] = 4'(32'(rq100) - 32'(rq1000) * 32'd10);
        n_rd[2] = 4'(32'(rq10) - 32'(rq100) * 32'd10);
        n_rd[3] = 4'(32'(r_rpm) - 32'(rq10) * 32'd10);
        aq100   = 4'((32'(r_adv) * 32'd5243) >> 19);
        aq10    = 7'((32'(r_adv) * 32'd52429) >> 19);
        n_ad[0] = aq100;
        n_ad[1] = 4'(32'(aq10) - 32'(aq100) * 32'd10);
        n_ad[2] = 4'(32'(r_adv) - 32'(aq10) * 32'd10);
    end

    always_ff @(posedge i_clk) begin
        r_rd     <= n_rd;
        r_ad     <= n_ad;
        r_over2  <= r_over;
        r_clamp2 <= r_clamp;
        r_avld2  <= r_avld;
    end

    assign o_vld       = r_vld2;
    assign o_rpm_d     = r_rd;
    assign o_adv_d     = r_ad;
    assign o_over      = r_over2;
    assign o_adv_valid = r_avld2;
    assign o_clamped   = r_clamp2;
endmodule

// ----- rtl/ignition_rpm_advance_calc_core.sv -----
// ---------------------------------------------------------------------------
// ignition_rpm_advance_calc_core
// ignition rpm and spark advance calculator with decimal outputs
// ---------------------------------------------------------------------------
// usage
//   request channel: drive the period, crank time and notch flag with start
//   high; the request is taken on any edge where busy is low. busy is
//   always low, so one request can enter on every clock.
//   results: each request yields one result, shown for one cycle with o_done
//   high; it passes the input register, the 32 divider cells, then the
//   clamping register and the digit split register.
//   throughput: one request per cycle, set by the row of 32 division cells
//   that each retire one quotient bit of both quotients and pass on.
//   config: write i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. write only while no request is in flight.
//   reset: synchronous active low; registers return to their defaults and
//   the pipeline valid bits clear, so no stray result appears.
//   the receiver cannot stall; results are never held back.
// ---------------------------------------------------------------------------
`include "ignition_rpm_advance_calc_core_assert.svh"
module ignition_rpm_advance_calc_core
    import irac_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [PerW-1:0] i_ignition_period,
    input  logic [PerW-1:0] i_crank_time,
    input  logic            i_crank_seen,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    output logic            o_done,
    output logic [3:0]      o_rpm_thousands,
    output logic [3:0]      o_rpm_hundreds,
    output logic [3:0]      o_rpm_tens,
    output logic [3:0]      o_rpm_ones,
    output logic            o_rpm_over,
    output logic [3:0]      o_adv_hundreds,
    output logic [3:0]      o_adv_tens,
    output logic [3:0]      o_adv_ones,
    output logic            o_adv_valid,
    output logic            o_adv_clamped
);
    // configuration registers
    logic [FacW-1:0] r_rpm_factor;
    logic [PerW-1:0] r_min_period;
    logic [OffW-1:0] r_notch_off;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_factor <= RpmFactorRst;
            r_min_period <= MinPeriodRst;
            r_notch_off  <= NotchOffRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegRpmFactor: r_rpm_factor <= i_cfg_data[FacW-1:0];
                RegMinPeriod: r_min_period <= i_cfg_data[PerW-1:0];
                RegNotchOff:  r_notch_off  <= i_cfg_data[OffW-1:0];
                default: ;
            endcase
        end
    end

    // input stage: register the request with its side flags and numerators
    t_cellbus r_in, n_in;
    logic     acc;
    logic [AngNumW-1:0] ang_num;
    logic [PerW-1:0]    den;

    assign acc     = start && !busy;
    // 180 * crank as shifts and adds
    assign ang_num = ({8'd0, i_crank_time} << 7) + ({8'd0, i_crank_time} << 5)
                   + ({8'd0, i_crank_time} << 4) + ({8'd0, i_crank_time} << 2);
    // zero period divides by one to keep the lanes defined; flags hide it
    assign den     = (i_ignition_period == '0) ? PerW'(1) : i_ignition_period;

    always_comb begin
        n_in.vld        = acc;
        n_in.side.over  = (i_ignition_period == '0) ||
                          (i_ignition_period < r_min_period);
        n_in.side.valid = i_crank_seen && (i_ignition_period != '0);
        n_in.side.off   = r_notch_off;
        n_in.rpm.num    = {{(QW-FacW){1'b0}}, r_rpm_factor};
        n_in.rpm.rem    = '0;
        n_in.rpm.quo    = '0;
        n_in.rpm.den    = den;
        n_in.ang.num    = ang_num;
        n_in.ang.rem    = '0;
        n_in.ang.quo    = '0;
        n_in.ang.den    = den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else begin
            r_in.vld <= n_in.vld;
        end
        r_in.side <= n_in.side;
        r_in.rpm  <= n_in.rpm;
        r_in.ang  <= n_in.ang;
    end

    // row of division cells, one quotient bit each
    t_cellbus chain [NumCell+1];
    assign chain[0] = r_in;

    for (genvar g = 0; g < NumCell; g++) begin : g_cell
        irac_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain[g]),
            .o_bus   (chain[g+1])
        );
    end

    logic [3:0] rpm_d [4];
    logic [3:0] adv_d [3];

    irac_digits u_digits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (chain[NumCell].vld),
        .i_side      (chain[NumCell].side),
        .i_rpm_q     (chain[NumCell].rpm.quo),
        .i_ang_q     (chain[NumCell].ang.quo),
        .o_vld       (o_done),
        .o_rpm_d     (rpm_d),
        .o_over      (o_rpm_over),
        .o_adv_d     (adv_d),
        .o_adv_valid (o_adv_valid),
        .o_clamped   (o_adv_clamped)
    );

    assign o_rpm_thousands = rpm_d[0];
    assign o_rpm_hundreds  = rpm_d[1];
    assign o_rpm_tens      = rpm_d[2];
    assign o_rpm_ones      = rpm_d[3];
    assign o_adv_hundreds  = adv_d[0];
    assign o_adv_tens      = adv_d[1];
    assign o_adv_ones      = adv_d[2];

    // a result with overflow shows all nines
    `IRA_ASSERT_IMP(a_over_nines, i_clk, i_rst_n, o_done && o_rpm_over,
        o_rpm_thousands == 4'd9 && o_rpm_ones == 4'd9)
    // advance digits are zero when not valid
    `IRA_ASSERT_IMP(a_adv_zero, i_clk, i_rst_n, o_done && !o_adv_valid,
        o_adv_hundreds == 4'd0 && !o_adv_clamped)
    // an accepted request enters the cell row next cycle
    `IRA_ASSERT_NEXT(a_enter, i_clk, i_rst_n, start, r_in.vld)
endmodule
